/* rtl/pfps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfps_pkg
// Types and constants shared by the portal funnel path smoother.
// ----------------------------------------------------------------------------
package pfps_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_LIMIT  = 64;
    localparam int OUT_CNT_W  = $clog2(OUT_LIMIT);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t left_x;
        coord_t left_y;
        coord_t left_z;
        coord_t right_x;
        coord_t right_y;
        coord_t right_z;
        logic   last_portal;
    } portal_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   last_point;
    } point_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vtx_t;

    typedef struct packed {
        vtx_t l;
        vtx_t r;
    } row_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

/* rtl/portal_funnel_path_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// portal_funnel_path_smoother
// Funnel path smoother over a corridor of portals, emitting waypoints.
// ----------------------------------------------------------------------------
// Input channel portal_valid / portal_stall / portal carries one portal item
// per handshake; the first is the start point, the item with last_portal set
// closes the corridor. Output channel point_valid / point_stall / point
// carries waypoints, the final one flagged by last_point.
// Loading: one portal per cycle through a two-entry queue into the store
// while the scan is idle. On the end item the scan starts: each portal
// step reads a portal row (S_LOOP), then runs each cross test through a
// multiply and a compare state (S_MUL, S_CMP), two to four tests per
// portal; every apex change restarts the scan just after the new apex.
// The store row read and the single cross-product unit set the scan's pace.
// The first waypoint is registered in S_START, reached through S_START_RD.
// Reset clears the counters, queue and output valid; the store needs none.
// While point_stall is high the waiting waypoint holds and the scan pauses
// at its next compare or emission; loading continues until the queue fills,
// then portal_stall rises.
// ----------------------------------------------------------------------------
module portal_funnel_path_smoother #(
    parameter int MAX_PORTALS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              portal_valid,
    output logic              portal_stall,
    input  pfps_pkg::portal_t portal,
    output logic              point_valid,
    input  logic              point_stall,
    output pfps_pkg::point_t  point
);

    // queue between front and back
    logic                push, pop;
    pfps_pkg::portal_t   push_item, head;
    pfps_pkg::q_status_t q_status;

    pfps_front #(.MAX_PORTALS(MAX_PORTALS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .portal_valid (portal_valid),
        .portal_stall (portal_stall),
        .portal       (portal),
        .q_status     (q_status),
        .push         (push),
        .push_item    (push_item)
    );

    pfps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    pfps_back #(.MAX_PORTALS(MAX_PORTALS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule

/* rtl/pfps_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfps_queue
// Two-entry queue of portal items between front and back.
// ----------------------------------------------------------------------------
module pfps_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pfps_pkg::portal_t  push_item,
    input  logic               pop,
    output pfps_pkg::portal_t  head,
    output pfps_pkg::q_status_t status
);

    pfps_pkg::portal_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == 2'd2);
    assign status.valid = (fill_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/pfps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfps_front
// Accept portal items, drop those that overflow the store, queue the rest.
// ----------------------------------------------------------------------------
module pfps_front #(
    parameter int MAX_PORTALS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                portal_valid,
    output logic                portal_stall,
    input  pfps_pkg::portal_t   portal,
    input  pfps_pkg::q_status_t q_status,
    output logic                push,
    output pfps_pkg::portal_t   push_item
);

    localparam int CNT_W = $clog2(MAX_PORTALS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept, drop;

    assign portal_stall = q_status.full;
    assign accept       = portal_valid && !q_status.full;
    // drop a plain portal once the store is full
    assign drop         = !portal.last_portal && (cnt_reg == CNT_W'(MAX_PORTALS));
    assign push         = accept && !drop;
    assign push_item    = portal;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (portal.last_portal)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/pfps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfps_back
// Store portals and run the funnel scan on the end item, emitting waypoints.
// ----------------------------------------------------------------------------
module pfps_back #(
    parameter int MAX_PORTALS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pfps_pkg::portal_t   head,
    input  pfps_pkg::q_status_t q_status,
    output logic                pop,
    output logic                point_valid,
    input  logic                point_stall,
    output pfps_pkg::point_t    point
);

    localparam int CW     = pfps_pkg::COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_PORTALS + 1);
    localparam int SLOT_W = $clog2(MAX_PORTALS);
    localparam int PW     = 2 * CW + 2;
    localparam int OW     = pfps_pkg::OUT_CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_START_RD, S_START, S_LOOP, S_MUL, S_CMP, S_FINAL
    } state_t;

    // which cross test is in flight
    typedef enum logic [1:0] {
        T_RGT_NR, T_LFT_NR, T_LFT_NL, T_RGT_NL
    } test_t;

    pfps_pkg::row_t mem [MAX_PORTALS];
    pfps_pkg::row_t rd_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;

    state_t state_reg, state_next;
    test_t  test_reg, test_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, n_reg, n_next, i_reg, i_next;
    logic [SLOT_W-1:0] lidx_reg, lidx_next, ridx_reg, ridx_next;
    pfps_pkg::vtx_t apex_reg, apex_next, lft_reg, lft_next, rgt_reg, rgt_next;
    pfps_pkg::vtx_t end_reg, end_next;
    logic [OW-1:0]  k_reg, k_next;
    logic signed [PW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    pfps_pkg::point_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    pfps_pkg::vtx_t opb, opc;
    logic signed [CW:0]   dbx, dbz, dcx, dcz;
    logic signed [PW:0]   diff;
    logic out_free, s_neg, s_zero;

    assign out_free    = !out_valid_reg || !point_stall;
    assign point_valid = out_valid_reg;
    assign point       = out_reg;

    assign wr_slot = (cnt_reg < CNT_W'(MAX_PORTALS)) ? cnt_reg[SLOT_W-1:0]
                                                    : SLOT_W'(MAX_PORTALS - 1);
    assign wr_en   = pop;
    // hold the scanned row steady through all tests of one portal
    assign rd_addr = (state_reg == S_START_RD) ? '0 : i_reg[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= '{l: '{x: head.left_x, y: head.left_y, z: head.left_z},
                              r: '{x: head.right_x, y: head.right_y, z: head.right_z}};
        end
        rd_reg <= mem[rd_addr];
    end

    // cross product operands: apex, funnel side, new corner
    always_comb
    begin
        opb = (test_reg == T_RGT_NR || test_reg == T_RGT_NL) ? rgt_reg : lft_reg;
        opc = (test_reg == T_RGT_NR || test_reg == T_LFT_NR) ? rd_reg.r : rd_reg.l;
        dbx = {opb.x[CW-1], opb.x} - {apex_reg.x[CW-1], apex_reg.x};
        dbz = {opb.z[CW-1], opb.z} - {apex_reg.z[CW-1], apex_reg.z};
        dcx = {opc.x[CW-1], opc.x} - {apex_reg.x[CW-1], apex_reg.x};
        dcz = {opc.z[CW-1], opc.z} - {apex_reg.z[CW-1], apex_reg.z};
        p1_next = PW'(dbx * dcz);
        p2_next = PW'(dbz * dcx);
        diff    = {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};
        s_neg   = diff[PW];
        s_zero  = (diff == '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        test_next      = test_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        lidx_next      = lidx_reg;
        ridx_next      = ridx_reg;
        apex_next      = apex_reg;
        lft_next       = lft_reg;
        rgt_next       = rgt_reg;
        end_next       = end_reg;
        k_next         = k_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && point_stall;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_status.valid)
                begin
                    pop = 1'b1;
                    if (head.last_portal)
                    begin
                        n_next     = CNT_W'(wr_slot) + CNT_W'(1);
                        end_next   = '{x: head.left_x, y: head.left_y, z: head.left_z};
                        cnt_next   = '0;
                        state_next = S_START_RD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_START_RD:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                if (out_free)
                begin
                    apex_next      = rd_reg.l;
                    lft_next       = rd_reg.l;
                    rgt_next       = rd_reg.r;
                    lidx_next      = '0;
                    ridx_next      = '0;
                    out_next       = '{point_x: rd_reg.l.x, point_y: rd_reg.l.y,
                                       point_z: rd_reg.l.z, last_point: 1'b0};
                    out_valid_next = 1'b1;
                    k_next         = OW'(1);
                    i_next         = CNT_W'(1);
                    state_next     = S_LOOP;
                end
            end
            S_LOOP:
            begin
                test_next  = T_RGT_NR;
                state_next = (i_reg < n_reg) ? S_MUL : S_FINAL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    state_next = S_MUL;
                    unique case (test_reg)
                        T_RGT_NR:
                        begin
                            if (s_neg || s_zero)
                            begin
                                if (apex_reg == rgt_reg)
                                begin
                                    rgt_next  = rd_reg.r;
                                    ridx_next = i_reg[SLOT_W-1:0];
                                    test_next = T_LFT_NL;
                                end
                                else
                                begin
                                    test_next = T_LFT_NR;
                                end
                            end
                            else
                            begin
                                test_next = T_LFT_NL;
                            end
                        end
                        T_LFT_NR:
                        begin
                            if (!s_neg && !s_zero)
                            begin
                                rgt_next  = rd_reg.r;
                                ridx_next = i_reg[SLOT_W-1:0];
                                test_next = T_LFT_NL;
                            end
                            else
                            begin
                                // left corner crosses: it becomes the apex
                                if (k_reg != OW'(pfps_pkg::OUT_LIMIT - 1))
                                begin
                                    out_next = '{point_x: lft_reg.x, point_y: lft_reg.y,
                                                 point_z: lft_reg.z, last_point: 1'b0};
                                    out_valid_next = 1'b1;
                                    k_next         = k_reg + OW'(1);
                                end
                                apex_next  = lft_reg;
                                rgt_next   = lft_reg;
                                ridx_next  = lidx_reg;
                                i_next     = CNT_W'(lidx_reg) + CNT_W'(1);
                                state_next = S_LOOP;
                            end
                        end
                        T_LFT_NL:
                        begin
                            if (!s_neg)
                            begin
                                if (apex_reg == lft_reg)
                                begin
                                    lft_next   = rd_reg.l;
                                    lidx_next  = i_reg[SLOT_W-1:0];
                                    i_next     = i_reg + CNT_W'(1);
                                    state_next = S_LOOP;
                                end
                                else
                                begin
                                    test_next = T_RGT_NL;
                                end
                            end
                            else
                            begin
                                i_next     = i_reg + CNT_W'(1);
                                state_next = S_LOOP;
                            end
                        end
                        T_RGT_NL:
                        begin
                            if (s_neg)
                            begin
                                lft_next  = rd_reg.l;
                                lidx_next = i_reg[SLOT_W-1:0];
                                i_next    = i_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // right corner crosses: it becomes the apex
                                if (k_reg != OW'(pfps_pkg::OUT_LIMIT - 1))
                                begin
                                    out_next = '{point_x: rgt_reg.x, point_y: rgt_reg.y,
                                                 point_z: rgt_reg.z, last_point: 1'b0};
                                    out_valid_next = 1'b1;
                                    k_next         = k_reg + OW'(1);
                                end
                                apex_next = rgt_reg;
                                lft_next  = rgt_reg;
                                lidx_next = ridx_reg;
                                i_next    = CNT_W'(ridx_reg) + CNT_W'(1);
                            end
                            state_next = S_LOOP;
                        end
                        default:
                        begin
                            state_next = S_LOOP;
                        end
                    endcase
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_next       = '{point_x: end_reg.x, point_y: end_reg.y,
                                       point_z: end_reg.z, last_point: 1'b1};
                    out_valid_next = 1'b1;
                    k_next         = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            test_reg      <= T_RGT_NR;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            lidx_reg      <= '0;
            ridx_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            test_reg      <= test_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            lidx_reg      <= lidx_next;
            ridx_reg      <= ridx_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        apex_reg <= apex_next;
        lft_reg  <= lft_next;
        rgt_reg  <= rgt_next;
        end_reg  <= end_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        out_reg  <= out_next;
    end

endmodule

/* tb/tb_portal_funnel_path_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_portal_funnel_path_smoother
// Corridors of portals go in; waypoints from a funnel predictor are compared.
// ----------------------------------------------------------------------------
// Each end item triggers the funnel predictor, which queues the expected
// waypoints in a scoreboard. Every waypoint the block emits is
// checked field by field against the oldest expected one. Directed corridors
// cover the extremes, lone end items, unequal start corners, apex on the end
// point and overflowing stores; random corridors follow under several
// idling phases, with a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_portal_funnel_path_smoother;

    localparam int NPORT = 64;

    // ------------------------------------------------------------------------
    // Scoreboard: holds expected waypoints, checks emitted ones
    // ------------------------------------------------------------------------
    class waypoint_board;
        pfps_pkg::point_t pending[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        function void note_portal(pfps_pkg::point_t pts[$]);
            foreach (pts[k]) pending = {pending, pts[k]};
        endfunction

        function void check_point(pfps_pkg::point_t got);
            pfps_pkg::point_t want;
            if (pending.size() == 0) begin
                $error("unexpected waypoint x=%0d z=%0d", got.point_x, got.point_z);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.point_x !== want.point_x) begin
                $error("point_x expected %0d got %0d", want.point_x, got.point_x);
                errors++;
            end
            if (got.point_y !== want.point_y) begin
                $error("point_y expected %0d got %0d", want.point_y, got.point_y);
                errors++;
            end
            if (got.point_z !== want.point_z) begin
                $error("point_z expected %0d got %0d", want.point_z, got.point_z);
                errors++;
            end
            if (got.last_point !== want.last_point) begin
                $error("last_point expected %0b got %0b", want.last_point, got.last_point);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              portal_valid;
    logic              portal_stall;
    pfps_pkg::portal_t portal;
    logic              point_valid;
    logic              point_stall;
    pfps_pkg::point_t  point;

    waypoint_board board;
    int  sent_items;
    int  ends_sent;
    int  cycles;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_off;

    // Predictor state: the corridor loaded so far
    pfps_pkg::vtx_t lcorner [NPORT];
    pfps_pkg::vtx_t rcorner [NPORT];
    int             loaded;

    portal_funnel_path_smoother #(.MAX_PORTALS(NPORT)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .portal_valid (portal_valid),
        .portal_stall (portal_stall),
        .portal       (portal),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Funnel predictor
    // ------------------------------------------------------------------------
    function automatic int cross_sign(pfps_pkg::vtx_t a, pfps_pkg::vtx_t b,
                                      pfps_pkg::vtx_t c);
        longint dbx, dbz, dcx, dcz, v;
        dbx = longint'(b.x) - longint'(a.x);
        dbz = longint'(b.z) - longint'(a.z);
        dcx = longint'(c.x) - longint'(a.x);
        dcz = longint'(c.z) - longint'(a.z);
        // differences fit in 25 bits, products in 50: no overflow in 64
        v = dbx * dcz - dbz * dcx;
        if (v < 0) return -1;
        if (v > 0) return 1;
        return 0;
    endfunction

    function automatic pfps_pkg::vtx_t corner_at(int idx, bit side);
        return side ? rcorner[idx] : lcorner[idx];
    endfunction

    function automatic void add_waypoint(ref pfps_pkg::point_t pts[$],
                                         input pfps_pkg::vtx_t v, input bit fin);
        pfps_pkg::point_t p;
        if (!fin && pts.size() >= pfps_pkg::OUT_LIMIT - 1) return;
        p.point_x    = v.x;
        p.point_y    = v.y;
        p.point_z    = v.z;
        p.last_point = fin;
        pts = {pts, p};
    endfunction

    // Load one portal; on an end item return the smoothed path.
    function automatic void smooth_path(pfps_pkg::portal_t it, ref pfps_pkg::point_t pts[$]);
        int   n, slot, i, ai, li, ri;
        bit   as, ls, rs;
        pfps_pkg::vtx_t apex, lft, rgt, nl, nr;
        pts.delete();
        if (!it.last_portal) begin
            // drop once the store is full
            if (loaded < NPORT) begin
                lcorner[loaded] = '{it.left_x, it.left_y, it.left_z};
                rcorner[loaded] = '{it.right_x, it.right_y, it.right_z};
                loaded++;
            end
            return;
        end
        slot = (loaded < NPORT) ? loaded : NPORT - 1;
        lcorner[slot] = '{it.left_x, it.left_y, it.left_z};
        rcorner[slot] = '{it.right_x, it.right_y, it.right_z};
        n = slot + 1;
        ai = 0; as = 0; li = 0; ls = 0; ri = 0; rs = 1;
        add_waypoint(pts, lcorner[0], 1'b0);
        i = 1;
        while (i < n) begin
            apex = corner_at(ai, as);
            lft  = corner_at(li, ls);
            rgt  = corner_at(ri, rs);
            nl   = lcorner[i];
            nr   = rcorner[i];
            if (cross_sign(apex, rgt, nr) <= 0) begin
                if (apex == rgt || cross_sign(apex, lft, nr) > 0) begin
                    ri = i; rs = 1; rgt = nr;
                end
                else begin
                    add_waypoint(pts, lft, 1'b0);
                    ai = li; as = ls; ri = ai; rs = as;
                    i = ai + 1;
                    continue;
                end
            end
            if (cross_sign(apex, lft, nl) >= 0) begin
                if (apex == lft || cross_sign(apex, rgt, nl) < 0) begin
                    li = i; ls = 0;
                end
                else begin
                    add_waypoint(pts, rgt, 1'b0);
                    ai = ri; as = rs; li = ai; ls = as;
                    i = ai + 1;
                    continue;
                end
            end
            i++;
        end
        add_waypoint(pts, lcorner[n-1], 1'b1);
        loaded = 0;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_portal(pfps_pkg::portal_t it);
        pfps_pkg::point_t pts[$];
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            portal_valid <= 1'b0;
            @(posedge clk);
        end
        portal_valid <= 1'b1;
        portal       <= it;
        @(posedge clk);
        while (portal_stall) @(posedge clk);
        // accepted at this edge: predict; valid stays up for a following item
        smooth_path(it, pts);
        board.note_portal(pts);
        sent_items++;
        if (it.last_portal) ends_sent++;
    endtask

    function automatic pfps_pkg::coord_t cv(int v);
        return pfps_pkg::coord_t'(v);
    endfunction

    function automatic pfps_pkg::coord_t rand_coord(int mode);
        case (mode)
            0: return pfps_pkg::coord_t'($urandom);
            1: return pfps_pkg::coord_t'($urandom_range(8191) - 4096);
            default: return pfps_pkg::coord_t'($urandom_range(65535) - 32768);
        endcase
    endfunction

    function automatic pfps_pkg::portal_t make_portal(
        pfps_pkg::coord_t lx, pfps_pkg::coord_t ly, pfps_pkg::coord_t lz,
        pfps_pkg::coord_t rx, pfps_pkg::coord_t ry, pfps_pkg::coord_t rz, bit fin);
        pfps_pkg::portal_t p;
        p.left_x = lx; p.left_y = ly; p.left_z = lz;
        p.right_x = rx; p.right_y = ry; p.right_z = rz;
        p.last_portal = fin;
        return p;
    endfunction

    // Corridor heading along +z with random widths; len counts inner portals
    task automatic send_corridor(int len, int mode);
        pfps_pkg::coord_t sx, sy, sz, w, z;
        sx = rand_coord(mode); sy = rand_coord(0); sz = rand_coord(mode);
        send_portal(make_portal(sx, sy, sz, sx, sy, sz, 1'b0));
        z = sz;
        for (int k = 0; k < len; k++) begin
            z = z + pfps_pkg::coord_t'($urandom_range(512, 1));
            w = pfps_pkg::coord_t'($urandom_range(600, 1));
            if ($urandom_range(9) == 0)
                send_portal(make_portal(rand_coord(0), rand_coord(0), rand_coord(0),
                                        rand_coord(0), rand_coord(0), rand_coord(0), 1'b0));
            else
                send_portal(make_portal(sx + rand_coord(1) / 4 - w, rand_coord(0), z,
                                        sx + rand_coord(1) / 4 + w, rand_coord(0), z, 1'b0));
        end
        z = z + pfps_pkg::coord_t'($urandom_range(512, 1));
        send_portal(make_portal(sx + rand_coord(1), rand_coord(0), z,
                                rand_coord(0), rand_coord(0), rand_coord(0), 1'b1));
    endtask

    task automatic wait_drained();
        portal_valid <= 1'b0;
        while (board.pending.size() != 0 && cycles < 2_000_000) @(posedge clk);
        // then idle on after the last waypoint of a corridor
        repeat (64) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall at random, or hold off for a long stretch
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_stall <= 1'b0;
        else if (hold_off)
            point_stall <= 1'b1;
        else
            point_stall <= (receiver_stall_pct > 0) &&
                           ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && point_valid && !point_stall) board.check_point(point);
    end

    // Long hold-off, counted here in cycles, started on request
    bit hold_req;
    initial
    begin
        hold_off = 1'b0;
        hold_req = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off <= 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    // Watchdog on total cycles
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2_000_000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pfps_pkg::coord_t mx, mn;
        board = new();
        loaded = 0;
        sent_items = 0;
        ends_sent = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        portal_valid = 1'b0;
        portal = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        mx = {1'b0, {(pfps_pkg::COORD_BITS-1){1'b1}}};
        mn = {1'b1, {(pfps_pkg::COORD_BITS-1){1'b0}}};

        // lone end item at the field extremes
        send_portal(make_portal(mx, mn, mx, mn, mx, mn, 1'b1));
        send_portal(make_portal(mn, mx, mn, mx, mn, mx, 1'b1));
        // unequal start corners, extreme coordinates, then an end
        send_portal(make_portal(mn, mn, mn, mx, mx, mx, 1'b0));
        send_portal(make_portal(mx, '0, mn, mn, '0, mx, 1'b0));
        send_portal(make_portal('0, mx, '0, mx, mn, mn, 1'b1));
        // zig-zag corridor where corners cross and the apex moves
        send_portal(make_portal(cv(0), cv(1), cv(0), cv(0), cv(1), cv(0), 1'b0));
        send_portal(make_portal(cv(-100), cv(2), cv(100), cv(100), cv(3), cv(100), 1'b0));
        send_portal(make_portal(cv(200), cv(4), cv(200), cv(400), cv(5), cv(200), 1'b0));
        send_portal(make_portal(cv(-400), cv(6), cv(300), cv(-200), cv(7), cv(300), 1'b0));
        send_portal(make_portal(cv(100), cv(8), cv(400), cv(300), cv(9), cv(400), 1'b0));
        // end point behind the funnel so it becomes an apex itself
        send_portal(make_portal(cv(-900), cv(10), cv(50), cv(900), cv(11), cv(50), 1'b1));
        // collinear points: zero cross products
        send_portal(make_portal(cv(0), cv(0), cv(0), cv(0), cv(0), cv(0), 1'b0));
        send_portal(make_portal(cv(0), cv(0), cv(10), cv(0), cv(0), cv(10), 1'b0));
        send_portal(make_portal(cv(0), cv(0), cv(20), cv(0), cv(0), cv(20), 1'b1));
        wait_drained();

        // overfull store: 71 items before the end, extra ones dropped
        send_corridor(70, 1);
        wait_drained();

        // random corridors across idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct    = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 55) : 0;
            receiver_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 55) : 0;
            if (ph == 2) hold_req = 1'b1;
            for (int c = 0; c < 4; c++)
                send_corridor($urandom_range(10, 1), $urandom_range(2));
            // pause until every waypoint has come
            if (ph == 1) wait_drained();
        end
        // a burst of noise items and a longer corridor
        for (int c = 0; c < 5; c++)
            send_portal(make_portal(rand_coord(0), rand_coord(0), rand_coord(0),
                                    rand_coord(0), rand_coord(0), rand_coord(0),
                                    1'($urandom_range(1))));
        send_portal(make_portal(cv(1), cv(1), cv(1), cv(1), cv(1), cv(1), 1'b1));
        send_corridor(16, 2);

        wait_drained();
        $display("Run covered %0d portal items, %0d corridors, extremes and overflow.",
                 sent_items, ends_sent);
        $display("Random idling and a long receiver hold-off were applied.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
        begin
            if (board.pending.size() != 0)
                $error("%0d expected waypoints never arrived", board.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
